@@ sv/fct_pkg.sv @@
package fct_pkg;

   // Default payload widths
   localparam int unsigned DATA_WIDTH_DEFAULT  = 16;
   localparam int unsigned ANGLE_WIDTH_DEFAULT = 16;

   // Sine/cosine datapath: Q2.30 in 32 bits, angle as 32 bits per turn
   localparam int unsigned TRIG_WIDTH    = 32;
   localparam int unsigned FRAC_BITS     = 30;
   localparam int unsigned CORDIC_STAGES = 20;

   localparam logic signed [TRIG_WIDTH-1:0] K_INV_SQRT3   = 32'sd619925131;
   localparam logic signed [TRIG_WIDTH-1:0] K_HALF_SQRT3  = 32'sd929887697;
   localparam logic signed [TRIG_WIDTH-1:0] K_CORDIC_INIT = 32'sd652032874;
   localparam logic signed [TRIG_WIDTH-1:0] QUARTER_TURN  = 32'sd1073741824;

   // Arctangent of 2^-i, in units of 2^-32 turn
   localparam logic signed [TRIG_WIDTH-1:0] ATAN_TURNS [0:CORDIC_STAGES-1] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
      32'sd21354465,  32'sd10679838,  32'sd5340245,   32'sd2670163,  32'sd1335087,
      32'sd667544,    32'sd333772,    32'sd166886,    32'sd83443,    32'sd41722,
      32'sd20861,     32'sd10430,     32'sd5215,      32'sd2608,     32'sd1304
   };

   typedef enum logic [1:0] {
      CMD_CLARKE     = 2'd0,
      CMD_PARK       = 2'd1,
      CMD_INV_PARK   = 2'd2,
      CMD_INV_CLARKE = 2'd3
   } cmd_type;

   // Control leaving the rotation pipeline
   typedef struct packed {
      logic    valid;
      logic    neg;
      cmd_type cmd;
   } trig_ctl_type;

endpackage

@@ sv/fct_req_if.sv @@
interface fct_req_if #(
   parameter int unsigned DATA_WIDTH  = fct_pkg::DATA_WIDTH_DEFAULT,
   parameter int unsigned ANGLE_WIDTH = fct_pkg::ANGLE_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   cmd;
   logic signed [DATA_WIDTH-1:0] in_a;
   logic signed [DATA_WIDTH-1:0] in_b;
   logic [ANGLE_WIDTH-1:0]       angle;

   modport source (output valid, cmd, in_a, in_b, angle, input ready);
   modport sink   (input valid, cmd, in_a, in_b, angle, output ready);
endinterface

@@ sv/fct_rsp_if.sv @@
interface fct_rsp_if #(
   parameter int unsigned DATA_WIDTH = fct_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] out_a;
   logic signed [DATA_WIDTH-1:0] out_b;
   logic signed [DATA_WIDTH-1:0] out_c;
   logic                         clipped;

   modport source (output valid, out_a, out_b, out_c, clipped, input ready);
   modport sink   (input valid, out_a, out_b, out_c, clipped, output ready);
endinterface

@@ sv/fct_cordic.sv @@
module fct_cordic #(
   parameter int unsigned DATA_WIDTH  = fct_pkg::DATA_WIDTH_DEFAULT,
   parameter int unsigned ANGLE_WIDTH = fct_pkg::ANGLE_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  fct_pkg::cmd_type                        in_cmd,
   input  logic signed [DATA_WIDTH-1:0]            in_a,
   input  logic signed [DATA_WIDTH-1:0]            in_b,
   input  logic [ANGLE_WIDTH-1:0]                  in_angle,
   input  logic                                    out_ready,
   output fct_pkg::trig_ctl_type                   out_ctl,
   output logic signed [fct_pkg::TRIG_WIDTH-1:0]   out_cos,
   output logic signed [fct_pkg::TRIG_WIDTH-1:0]   out_sin,
   output logic signed [DATA_WIDTH-1:0]            out_a,
   output logic signed [DATA_WIDTH-1:0]            out_b
);

   localparam int unsigned NS = fct_pkg::CORDIC_STAGES;
   localparam int unsigned CW = fct_pkg::TRIG_WIDTH;

   logic [NS:0] valid_ff;
   logic [NS:0] valid_in;
   logic [NS:0] adv;

   logic                         neg_ff [0:NS];
   logic                         neg_in [0:NS];
   fct_pkg::cmd_type             cmd_ff [0:NS];
   fct_pkg::cmd_type             cmd_in [0:NS];
   logic signed [DATA_WIDTH-1:0] a_ff   [0:NS];
   logic signed [DATA_WIDTH-1:0] a_in   [0:NS];
   logic signed [DATA_WIDTH-1:0] b_ff   [0:NS];
   logic signed [DATA_WIDTH-1:0] b_in   [0:NS];
   logic signed [CW-1:0]         x_ff   [0:NS];
   logic signed [CW-1:0]         x_in   [0:NS];
   logic signed [CW-1:0]         y_ff   [0:NS];
   logic signed [CW-1:0]         y_in   [0:NS];
   logic signed [CW-1:0]         z_ff   [0:NS];
   logic signed [CW-1:0]         z_in   [0:NS];

   logic signed [CW-1:0] turn;
   logic                 fold;

   // Widen the angle to a 32-bit turn and fold it into [-1/4, +1/4] turn
   always_comb begin
      turn       = {in_angle, {(CW-ANGLE_WIDTH){1'b0}}};
      fold       = (turn > fct_pkg::QUARTER_TURN) || (turn < -fct_pkg::QUARTER_TURN);
      // adding or subtracting half a turn flips the top bit
      z_in[0]    = fold ? {~turn[CW-1], turn[CW-2:0]} : turn;
      x_in[0]    = fct_pkg::K_CORDIC_INIT;
      y_in[0]    = '0;
      neg_in[0]  = fold;
      cmd_in[0]  = in_cmd;
      a_in[0]    = in_a;
      b_in[0]    = in_b;
      valid_in[0] = in_valid;
   end

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;

      always_comb begin
         dx = y_ff[g] >>> g;
         dy = x_ff[g] >>> g;
         if (!z_ff[g][CW-1]) begin
            x_in[g+1] = x_ff[g] - dx;
            y_in[g+1] = y_ff[g] + dy;
            z_in[g+1] = z_ff[g] - fct_pkg::ATAN_TURNS[g];
         end else begin
            x_in[g+1] = x_ff[g] + dx;
            y_in[g+1] = y_ff[g] - dy;
            z_in[g+1] = z_ff[g] + fct_pkg::ATAN_TURNS[g];
         end
         neg_in[g+1]   = neg_ff[g];
         cmd_in[g+1]   = cmd_ff[g];
         a_in[g+1]     = a_ff[g];
         b_in[g+1]     = b_ff[g];
         valid_in[g+1] = valid_ff[g];
      end
   end

   // A stage moves when the output is ready or any stage from it onwards is empty
   for (genvar k = 0; k <= NS; k++) begin : g_adv
      assign adv[k] = out_ready || !(&valid_ff[NS:k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k <= NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NS; k++) begin
         if (adv[k]) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            z_ff[k]   <= z_in[k];
            neg_ff[k] <= neg_in[k];
            cmd_ff[k] <= cmd_in[k];
            a_ff[k]   <= a_in[k];
            b_ff[k]   <= b_in[k];
         end
      end
   end

   assign in_ready    = adv[0];
   assign out_ctl     = '{valid: valid_ff[NS], neg: neg_ff[NS], cmd: cmd_ff[NS]};
   assign out_cos     = x_ff[NS];
   assign out_sin     = y_ff[NS];
   assign out_a       = a_ff[NS];
   assign out_b       = b_ff[NS];

endmodule

@@ sv/foc_coordinate_transform_core.sv @@
// Throughput: one transfer per clock while the response side accepts; every one of the
// 24 register stages (fold, 20 CORDIC rotations, multiply, sum, saturate) takes a new
// item each cycle unless backpressure holds it.
// Backpressure stalls only the full stages at the tail; bubbles further up still close.
// Reset: synchronous, active high; clears the valid bits only, no clearing pass.
module foc_coordinate_transform_core #(
   parameter int unsigned DATA_WIDTH  = fct_pkg::DATA_WIDTH_DEFAULT,
   parameter int unsigned ANGLE_WIDTH = fct_pkg::ANGLE_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   fct_req_if.sink   req_port,
   fct_rsp_if.source rsp_port
);

   localparam int unsigned CW   = fct_pkg::TRIG_WIDTH;
   localparam int unsigned FB   = fct_pkg::FRAC_BITS;
   localparam int unsigned XW   = DATA_WIDTH + 2;     // a + 2b, or a negated
   localparam int unsigned PW   = XW + CW;            // full product
   localparam int unsigned ACCW = PW + 2;             // sum of two products plus rounding
   localparam int unsigned SW   = ACCW - FB;          // after the Q30 shift

   localparam logic signed [ACCW-1:0] ROUND_HALF = ACCW'(1) <<< (FB - 1);
   localparam logic signed [SW-1:0]   SAT_MAX    =
      {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0]   SAT_MIN    =
      {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   // ---------------------------------------------------------------------------
   // Rotation pipeline: sine and cosine of the angle, operands carried alongside
   // ---------------------------------------------------------------------------
   fct_pkg::trig_ctl_type        trig_ctl;
   logic signed [CW-1:0]         trig_cos;
   logic signed [CW-1:0]         trig_sin;
   logic signed [DATA_WIDTH-1:0] trig_a;
   logic signed [DATA_WIDTH-1:0] trig_b;
   logic                         trig_ready;

   fct_cordic #(
      .DATA_WIDTH  (DATA_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_fct_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_port.valid),
      .in_ready  (req_port.ready),
      .in_cmd    (fct_pkg::cmd_type'(req_port.cmd)),
      .in_a      (req_port.in_a),
      .in_b      (req_port.in_b),
      .in_angle  (req_port.angle),
      .out_ready (trig_ready),
      .out_ctl   (trig_ctl),
      .out_cos   (trig_cos),
      .out_sin   (trig_sin),
      .out_a     (trig_a),
      .out_b     (trig_b)
   );

   // ---------------------------------------------------------------------------
   // Tail handshake: a stage advances when rsp is ready or it or a later stage is empty
   // ---------------------------------------------------------------------------
   logic p_valid_ff;
   logic q_valid_ff;
   logic r_valid_ff;
   logic adv_p;
   logic adv_q;
   logic adv_r;

   assign adv_r      = rsp_port.ready || !r_valid_ff;
   assign adv_q      = adv_r || !q_valid_ff;
   assign adv_p      = adv_q || !p_valid_ff;
   assign trig_ready = adv_p;

   // ---------------------------------------------------------------------------
   // Multiply stage: four products, operands chosen by the command
   //   Clarke:         (a + 2b) * 1/sqrt3
   //   Park / inverse: a*cos, b*sin, b*cos, a*sin
   //   Inverse Clarke: b * sqrt3/2 (the a/2 term is a shift, added later)
   // ---------------------------------------------------------------------------
   logic signed [XW-1:0]         a_x;
   logic signed [XW-1:0]         b_x;
   logic signed [XW-1:0]         a_rot;
   logic signed [XW-1:0]         b_rot;
   logic signed [XW-1:0]         x_op [0:3];
   logic signed [CW-1:0]         y_op [0:3];
   logic signed [PW-1:0]         prod_in [0:3];
   logic signed [PW-1:0]         prod_ff [0:3];
   fct_pkg::cmd_type             p_cmd_ff;
   logic signed [DATA_WIDTH-1:0] p_a_ff;

   always_comb begin
      a_x = XW'(trig_a);
      b_x = XW'(trig_b);
      // the fold negated sine and cosine: negate the operands instead
      a_rot = trig_ctl.neg ? -a_x : a_x;
      b_rot = trig_ctl.neg ? -b_x : b_x;
      for (int j = 0; j < 4; j++) begin
         x_op[j] = '0;
         y_op[j] = '0;
      end
      unique case (trig_ctl.cmd)
         fct_pkg::CMD_CLARKE: begin
            x_op[0] = a_x + (b_x <<< 1);
            y_op[0] = fct_pkg::K_INV_SQRT3;
         end
         fct_pkg::CMD_PARK, fct_pkg::CMD_INV_PARK: begin
            x_op[0] = a_rot;
            y_op[0] = trig_cos;
            x_op[1] = b_rot;
            y_op[1] = trig_sin;
            x_op[2] = b_rot;
            y_op[2] = trig_cos;
            x_op[3] = a_rot;
            y_op[3] = trig_sin;
         end
         fct_pkg::CMD_INV_CLARKE: begin
            x_op[0] = b_x;
            y_op[0] = fct_pkg::K_HALF_SQRT3;
         end
         default: begin
            x_op[0] = '0;
         end
      endcase
      for (int j = 0; j < 4; j++) begin
         prod_in[j] = PW'(x_op[j]) * PW'(y_op[j]);
      end
   end

   // ---------------------------------------------------------------------------
   // Sum stage: combine products per command, add half an LSB for rounding
   // ---------------------------------------------------------------------------
   logic signed [ACCW-1:0]       m [0:3];
   logic signed [ACCW-1:0]       a_hi;
   logic signed [ACCW-1:0]       a_mid;
   logic signed [ACCW-1:0]       acc_in [0:2];
   logic signed [ACCW-1:0]       acc_ff [0:2];

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         m[j] = ACCW'(prod_ff[j]);
      end
      a_hi  = ACCW'(p_a_ff) <<< FB;          // passes a straight through the shift
      a_mid = ACCW'(p_a_ff) <<< (FB - 1);    // a / 2 in Q30
      acc_in[0] = a_hi;
      acc_in[1] = '0;
      acc_in[2] = '0;
      unique case (p_cmd_ff)
         fct_pkg::CMD_CLARKE: begin
            acc_in[1] = m[0] + ROUND_HALF;
         end
         fct_pkg::CMD_PARK: begin
            acc_in[0] = m[0] + m[1] + ROUND_HALF;
            acc_in[1] = m[2] - m[3] + ROUND_HALF;
         end
         fct_pkg::CMD_INV_PARK: begin
            acc_in[0] = m[0] - m[1] + ROUND_HALF;
            acc_in[1] = m[3] + m[2] + ROUND_HALF;
         end
         fct_pkg::CMD_INV_CLARKE: begin
            acc_in[1] = m[0] - a_mid + ROUND_HALF;
            acc_in[2] = -m[0] - a_mid + ROUND_HALF;
         end
         default: begin
            acc_in[0] = a_hi;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Saturate stage: drop the fraction, clamp each lane, flag any clamp
   // ---------------------------------------------------------------------------
   logic signed [SW-1:0]         shifted [0:2];
   logic signed [DATA_WIDTH-1:0] out_in  [0:2];
   logic signed [DATA_WIDTH-1:0] out_ff  [0:2];
   logic [2:0]                   lane_clip;
   logic                         clipped_in;
   logic                         clipped_ff;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         shifted[j]   = SW'(acc_ff[j] >>> FB);
         lane_clip[j] = 1'b0;
         if (shifted[j] > SAT_MAX) begin
            out_in[j]    = SAT_MAX[DATA_WIDTH-1:0];
            lane_clip[j] = 1'b1;
         end else if (shifted[j] < SAT_MIN) begin
            out_in[j]    = SAT_MIN[DATA_WIDTH-1:0];
            lane_clip[j] = 1'b1;
         end else begin
            out_in[j]    = shifted[j][DATA_WIDTH-1:0];
         end
      end
      clipped_in = |lane_clip;
   end

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         if (adv_p) begin
            p_valid_ff <= trig_ctl.valid;
         end
         if (adv_q) begin
            q_valid_ff <= p_valid_ff;
         end
         if (adv_r) begin
            r_valid_ff <= q_valid_ff;
         end
      end
   end

   // Hold payload while stalled; advance it with the valid bits
   always_ff @(posedge clock) begin
      if (adv_p) begin
         prod_ff  <= prod_in;
         p_cmd_ff <= trig_ctl.cmd;
         p_a_ff   <= trig_a;
      end
      if (adv_q) begin
         acc_ff <= acc_in;
      end
      if (adv_r) begin
         out_ff     <= out_in;
         clipped_ff <= clipped_in;
      end
   end

   assign rsp_port.valid   = r_valid_ff;
   assign rsp_port.out_a   = out_ff[0];
   assign rsp_port.out_b   = out_ff[1];
   assign rsp_port.out_c   = out_ff[2];
   assign rsp_port.clipped = clipped_ff;

endmodule

@@ sv/fct_checker.sv @@
module fct_checker #(
   parameter int unsigned DATA_WIDTH = fct_pkg::DATA_WIDTH_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_out_a,
   input logic signed [DATA_WIDTH-1:0] rsp_out_b,
   input logic signed [DATA_WIDTH-1:0] rsp_out_c,
   input logic                         rsp_clipped
);

   localparam logic signed [DATA_WIDTH-1:0] RAIL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] RAIL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_a) && $stable(rsp_out_b)
         && $stable(rsp_out_c) && $stable(rsp_clipped))
      else $error("stalled result changed");

   // Output taken or empty: the whole pipe can move, so the input is open
   a_ready_when_drained: assert property (@(posedge clock)
      rsp_ready || !rsp_valid |-> req_ready)
      else $error("input closed while output side drains");

   // A clamp leaves at least one field on a rail
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_out_a == RAIL_MAX || rsp_out_a == RAIL_MIN ||
         rsp_out_b == RAIL_MAX || rsp_out_b == RAIL_MIN ||
         rsp_out_c == RAIL_MAX || rsp_out_c == RAIL_MIN)
      else $error("clip flag without a saturated field");

   // Reset empties the pipe
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result present straight after reset");

   // Nothing enters during reset
   a_no_transfer_in_reset: assert property (@(posedge clock)
      $past(reset) && $past(req_valid) && reset |=> !rsp_valid)
      else $error("transfer slipped through reset");

endmodule

bind foc_coordinate_transform_core fct_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_fct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_out_a   (rsp_port.out_a),
   .rsp_out_b   (rsp_port.out_b),
   .rsp_out_c   (rsp_port.out_c),
   .rsp_clipped (rsp_port.clipped)
);
